// ----- sv/bee_pkg.sv -----
// Package for the byte entropy estimator: sizes, reset values and helpers.
// No dependencies.
package bee_pkg;
	localparam int CountBits     = 24;
	localparam int FracBits      = 12;
	localparam int NumBins       = 256;
	localparam int BinIdxBits    = 8;
	localparam int OutFrac       = 12;
	localparam int ThreshBits    = 16;
	localparam int ByteCountBits = 24;
	localparam logic [ThreshBits-1:0] ThresholdReset = 16'd29491;
	localparam logic [16:0] EntropyMaxQ12 = 17'd32768;

	// log2 unit request/response between top and the log2 unit
	typedef struct packed {
		logic        start;
		logic [63:0] x;
	} log2_req_t;

	typedef struct packed {
		logic        done;
		logic [69:0] value; // Q6.FracBits, 6+FracBits bits used
	} log2_rsp_t;
endpackage

// ----- sv/bee_log2.sv -----
// Iterative fixed-point log2: one normalize step, then one squaring per
// fraction bit. Depends on bee_pkg.
module bee_log2
	import bee_pkg::*;
#(
	parameter int FRAC_BITS = FracBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  log2_req_t req,
	output log2_rsp_t rsp
);
	typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ, L_DONE} lstate_t;

	localparam int StepBits = $clog2(FRAC_BITS + 1);

	lstate_t             state_q;
	logic [63:0]         x_q;
	logic [5:0]          e_q;
	logic [32:0]         m_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [StepBits-1:0] step_q;
	logic                done_q;

	logic [5:0]  msb;
	logic [65:0] sq;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 64; i++) begin
			if (x_q[i]) msb = 6'(i);
		end
	end

	// m is below 2^33, so the product fits 66 bits
	assign sq = 66'(m_q) * 66'(m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (req.start) begin
						x_q     <= req.x;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					e_q    <= msb;
					frac_q <= '0;
					step_q <= '0;
					if (msb >= 6'd31) m_q <= 33'(x_q >> (msb - 6'd31));
					else              m_q <= 33'(x_q << (6'd31 - msb));
					state_q <= L_SQ;
				end
				L_SQ: begin
					if (sq[65:31] >= 35'h1_0000_0000) begin
						m_q    <= 33'(sq[65:32]);
						frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
					end else begin
						m_q    <= 33'(sq[65:31]);
						frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
					end
					if (step_q == StepBits'(FRAC_BITS - 1)) state_q <= L_DONE;
					step_q <= step_q + 1'b1;
				end
				L_DONE: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = 70'({e_q, frac_q});
endmodule

// ----- sv/bee_divider.sv -----
// Restoring divider, one quotient bit per cycle: 64-bit sum by count.
// Depends on bee_pkg.
module bee_divider
	import bee_pkg::*;
#(
	parameter int COUNT_BITS = CountBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  done,
	output logic [63:0]           quotient
);
	logic [63:0]           q_q;
	logic [COUNT_BITS:0]   r_q;
	logic [COUNT_BITS-1:0] d_q;
	logic [6:0]            cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;

	assign trial = {r_q[COUNT_BITS-1:0], q_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q    <= dividend;
				r_q    <= '0;
				d_q    <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (trial >= {1'b0, d_q}) begin
					r_q <= trial - {1'b0, d_q};
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					r_q <= trial;
					q_q <= {q_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

// ----- sv/byte_entropy_estimator.sv -----
// Byte entropy estimator top level: histogram memory, sequencer and output.
// Depends on bee_pkg, bee_log2 and bee_divider.
//
// Bytes are counted into a 256-bin histogram by a read-modify-write, so a
// transaction with has_byte set holds in_stall for the cycle after it and
// bytes cannot go in back to back; while the block is idle, items with
// neither has_byte nor last_item go in every cycle. An item with last_item
// set starts the entropy pass once any earlier result has been taken: a
// start step, log2 of the total, then per bin a memory read and, for a
// nonzero bin, a log2 in the shared squaring unit, a multiply and an
// accumulate, then a 64-step bit-serial divide and an output step. An empty
// file gives its result straight from the idle state, with no log2 or
// divide. The histogram is cleared during the pass as each bin is read, so
// no separate clearing sweep is needed. After reset a clearing pass writes
// zero to all 256 bins before the first byte is taken. in_stall is high
// through both passes and while a finished file waits for its pass to start.
module byte_entropy_estimator
	import bee_pkg::*;
#(
	parameter int COUNT_BITS = CountBits,
	parameter int FRAC_BITS  = FracBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            byte_value,
	input  logic                  has_byte,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           entropy_q12,
	output logic                  above_threshold,
	output logic [23:0]           byte_count,
	output logic                  count_overflow,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ThreshBits-1:0] cfg_data
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LN, S_LN_W, S_RD, S_RD_W, S_BIN, S_LC_W, S_MUL,
		S_ACC, S_DIV, S_DIV_W, S_OUT
	} state_t;

	localparam logic [COUNT_BITS-1:0] CountMax = '1;
	localparam int DBits    = FRAC_BITS + 6;
	localparam int ProdBits = COUNT_BITS + DBits;

	state_t                state_q;
	logic [COUNT_BITS-1:0] mem [NumBins];
	logic [COUNT_BITS-1:0] rd_s1;
	logic [BinIdxBits-1:0] idx_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  ovf_q;
	logic [ThreshBits-1:0] thresh_q;
	logic [69:0]           ln_q;
	logic [DBits-1:0]      d_q;
	logic [63:0]           acc_q;
	logic [COUNT_BITS-1:0] bin_q;
	logic [ProdBits-1:0]   prod_q;
	logic                  out_valid_q;
	logic [15:0]           ent_q;
	logic                  above_q;
	logic [23:0]           cnt_q;
	logic                  ovfo_q;

	// byte counting path: read-modify-write, read registered in rd_s1, write held by wr_pend_q
	logic                  wr_pend_q;
	logic [BinIdxBits-1:0] wr_idx_q;
	logic                  fin_pend_q;

	log2_req_t lreq;
	log2_rsp_t lrsp;
	logic      div_start;
	logic      div_done;
	logic [63:0] quot;

	bee_log2 #(.FRAC_BITS(FRAC_BITS)) u_log2 (
		.clk(clk), .arst_n(arst_n), .req(lreq), .rsp(lrsp)
	);

	bee_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(acc_q),
		.divisor(total_q), .done(div_done), .quotient(quot)
	);

	logic in_acc;
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || wr_pend_q || fin_pend_q;
	assign cfg_ready = 1'b1;

	// scaled result to Q12 with clamp
	logic [63:0] h_q12;
	always_comb begin
		if (FRAC_BITS >= OutFrac) begin
			h_q12 = quot >> (FRAC_BITS - OutFrac);
		end else if (quot > (64'(EntropyMaxQ12) >> (OutFrac - FRAC_BITS))) begin
			h_q12 = 64'(EntropyMaxQ12);
		end else begin
			h_q12 = quot << (OutFrac - FRAC_BITS);
		end
		if (h_q12 > 64'(EntropyMaxQ12)) h_q12 = 64'(EntropyMaxQ12);
	end

	// memory: one write, one registered read
	logic                  mem_we;
	logic [BinIdxBits-1:0] mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;
	logic [BinIdxBits-1:0] mem_ra;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = '0;
		mem_ra = in_acc ? byte_value : idx_q;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (wr_pend_q) begin
			mem_we = rd_s1 != CountMax;
			mem_wa = wr_idx_q;
			mem_wd = rd_s1 + 1'b1;
		end else if (state_q == S_BIN) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[mem_ra];
	end

	logic [69:0] lc;
	assign lc = lrsp.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			thresh_q    <= ThresholdReset;
			out_valid_q <= 1'b0;
			wr_pend_q   <= 1'b0;
			fin_pend_q  <= 1'b0;
			lreq        <= '0;
			div_start   <= 1'b0;
		end else begin
			lreq.start <= 1'b0;
			div_start  <= 1'b0;
			wr_pend_q  <= 1'b0;
			if (cfg_valid && cfg_ready) thresh_q <= cfg_data;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (in_acc) begin
				wr_pend_q   <= has_byte;
				wr_idx_q    <= byte_value;
				fin_pend_q  <= last_item;
				if (has_byte) begin
					if (total_q == CountMax) ovf_q <= 1'b1;
					else                      total_q <= total_q + 1'b1;
				end
			end
			if (wr_pend_q && rd_s1 == CountMax) ovf_q <= 1'b1;
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == BinIdxBits'(NumBins - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					// a finished file waits until the previous result is taken
					if (fin_pend_q && !wr_pend_q && !in_acc && !out_valid_q) begin
						fin_pend_q <= 1'b0;
						acc_q      <= '0;
						idx_q      <= '0;
						if (total_q == '0) begin
							ent_q       <= '0;
							above_q     <= 1'b0;
							cnt_q       <= '0;
							ovfo_q      <= ovf_q;
							ovf_q       <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							lreq.start <= 1'b1;
							lreq.x     <= 64'(total_q);
							state_q    <= S_LN_W;
						end
					end
				end
				S_LN_W: begin
					if (lrsp.done) begin
						ln_q    <= lrsp.value;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_RD_W;
				S_RD_W: state_q <= S_BIN;
				S_BIN: begin
					// rd_s1 holds bin idx_q; it is cleared this cycle
					if (rd_s1 != '0) begin
						lreq.start <= 1'b1;
						lreq.x     <= 64'(rd_s1);
						bin_q      <= rd_s1;
						state_q    <= S_LC_W;
					end else if (idx_q == BinIdxBits'(NumBins - 1)) begin
						div_start <= 1'b1;
						state_q   <= S_DIV_W;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_LC_W: begin
					if (lrsp.done) begin
						d_q     <= (ln_q > lc) ? DBits'(ln_q - lc) : '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= ProdBits'(bin_q) * ProdBits'(d_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					logic [63:0] t;
					logic [64:0] s;
					t = (prod_q > ProdBits'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : 64'(prod_q);
					s = {1'b0, acc_q} + {1'b0, t};
					acc_q <= s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
					if (idx_q == BinIdxBits'(NumBins - 1)) begin
						div_start <= 1'b1;
						state_q   <= S_DIV_W;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DIV_W: begin
					if (div_done) state_q <= S_OUT;
				end
				S_OUT: begin
					ent_q   <= h_q12[15:0];
					above_q <= h_q12 > 64'(thresh_q);
					cnt_q   <= (64'(total_q) > 64'd16777215) ? 24'hFF_FFFF : 24'(total_q);
					ovfo_q  <= ovf_q;
					ovf_q   <= 1'b0;
					total_q <= '0;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign entropy_q12     = ent_q;
	assign above_threshold = above_q;
	assign byte_count      = cnt_q;
	assign count_overflow  = ovfo_q;
endmodule

// ----- test/byte_entropy_estimator_test.sv -----
// Testbench for byte_entropy_estimator: byte files in, entropy results out.
// Depends on bee_pkg and the block's RTL; expected results come from a local histogram model or a typed row.
`timescale 1ns / 1ps

module byte_entropy_estimator_test;
	import bee_pkg::*;

	localparam int IdleLimit  = 20000;
	localparam int LongHold   = 1500;
	localparam int RandItems  = 1900;
	localparam int DrainWait  = 40;
	localparam logic [23:0] BinMax = 24'hFFFFFF;

	typedef struct {
		logic [15:0] ent;
		logic        above;
		logic [23:0] cnt;
		logic        ovf;
	} entropy_result_t;

	typedef struct {
		logic [7:0]  b;
		logic        has;
		logic        last;
		bit          typed;
		logic [15:0] ent;
		logic        above;
		logic [23:0] cnt;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] byte_value = '0;
	logic has_byte = 1'b0;
	logic last_item = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] entropy_q12;
	logic above_threshold;
	logic [23:0] byte_count;
	logic count_overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ThreshBits-1:0] cfg_data = '0;

	byte_entropy_estimator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.byte_value(byte_value), .has_byte(has_byte), .last_item(last_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.entropy_q12(entropy_q12), .above_threshold(above_threshold),
		.byte_count(byte_count), .count_overflow(count_overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the block state
	logic [23:0] hist [NumBins];
	logic [23:0] hist_total;
	logic        hist_ovf;
	logic [15:0] threshold;

	entropy_result_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int hold_reqs = 0;
	int burst_left = 0;
	bit no_idle = 1'b0;

	function automatic logic [63:0] log2_q(logic [63:0] x);
		int e;
		logic [63:0] m, frac;
		if (x == 0)
			return '0;
		e = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		frac = '0;
		for (int i = 0; i < FracBits; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return (64'(e) << FracBits) | frac;
	endfunction

	// counts are 24 bits, so c*d and the sum stay far below 2^64
	function automatic logic [15:0] entropy_of_hist();
		logic [63:0] n, ln, lc, d, acc, h;
		n = 64'(hist_total);
		if (n == 0)
			return '0;
		ln = log2_q(n);
		acc = '0;
		for (int i = 0; i < NumBins; i++) begin
			if (hist[i] != 0) begin
				lc = log2_q(64'(hist[i]));
				d = (ln > lc) ? ln - lc : '0;
				acc = acc + 64'(hist[i]) * d;
			end
		end
		h = acc / n;
		if (h > 64'(EntropyMaxQ12))
			h = 64'(EntropyMaxQ12);
		return h[15:0];
	endfunction

	task automatic clear_hist();
		foreach (hist[i])
			hist[i] = '0;
		hist_total = '0;
		hist_ovf = 1'b0;
	endtask

	task automatic count_byte(stim_row_t r);
		entropy_result_t res;
		if (r.has) begin
			if (hist[r.b] == BinMax)
				hist_ovf = 1'b1;
			else
				hist[r.b]++;
			if (hist_total == BinMax)
				hist_ovf = 1'b1;
			else
				hist_total++;
		end
		if (r.last) begin
			if (r.typed) begin
				res.ent = r.ent;
				res.above = r.above;
				res.cnt = r.cnt;
				res.ovf = 1'b0;
			end else begin
				res.ent = entropy_of_hist();
				res.above = res.ent > threshold;
				res.cnt = hist_total;
				res.ovf = hist_ovf;
			end
			pending_results = {pending_results, res};
			clear_hist();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// called at a rising edge; returns at the edge where the transaction is taken, or after the idle gap after it
	task automatic send_item(stim_row_t r);
		int gap;
		in_valid <= 1'b1;
		byte_value <= r.b;
		has_byte <= r.has;
		last_item <= r.last;
		do @(posedge clk); while (in_stall);
		count_byte(r);
		if (r.has || r.last)
			items_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			no_idle = ($urandom_range(0, 3) == 0);
		end
		burst_left--;
		gap = (burst_left == 0 && !no_idle) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= 16'($urandom);
		threshold = v;
		@(posedge clk);
	endtask

	task automatic send_file();
		stim_row_t r;
		int len, mode;
		logic [7:0] base, alt;
		bit tail_end;
		r.typed = 0;
		len = $urandom_range(0, 99);
		if (len < 5)
			len = 0;
		else if (len < 92)
			len = $urandom_range(1, 48);
		else
			len = $urandom_range(100, 300);
		mode = $urandom_range(0, 3);
		base = 8'($urandom);
		alt = 8'($urandom);
		tail_end = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				r.b = 8'($urandom);
				r.has = 0;
				r.last = 0;
				send_item(r);
			end
			case (mode)
			0: r.b = 8'($urandom);
			1: r.b = $urandom_range(0, 1) ? base : alt;
			2: r.b = {base[7:4], 4'($urandom)};
			default: r.b = base;
			endcase
			r.has = 1;
			r.last = !tail_end && (i == len - 1);
			send_item(r);
		end
		if (tail_end) begin
			r.b = 8'($urandom);
			r.has = 0;
			r.last = 1;
			send_item(r);
		end
	endtask

	// result checker and receiver stall pattern
	int hold_seen = 0;
	int hold_left = 0;
	int stall_pct = 0;
	int pattern_cnt = 0;
	always @(posedge clk) begin
		entropy_result_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'd1, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (entropy_q12 !== want.ent)
					report_mismatch("entropy_q12", 32'(entropy_q12), 32'(want.ent));
				if (above_threshold !== want.above)
					report_mismatch("above_threshold", 32'(above_threshold),
						32'(want.above));
				if (byte_count !== want.cnt)
					report_mismatch("byte_count", 32'(byte_count), 32'(want.cnt));
				if (count_overflow !== want.ovf)
					report_mismatch("count_overflow", 32'(count_overflow), 32'(want.ovf));
			end
		end
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = LongHold;
		end
		if (pattern_cnt == 0) begin
			pattern_cnt = $urandom_range(16, 200);
			case ($urandom_range(0, 2))
			0: stall_pct = 0;
			1: stall_pct = 30;
			default: stall_pct = 80;
			endcase
		end
		pattern_cnt--;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog on cycles with no transaction on any channel
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	stim_row_t directed[] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, 16'd0,    1'b0, 24'd0},
		'{8'h00, 1'b1, 1'b1, 1'b1, 16'd0,    1'b0, 24'd1},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'hFF, 1'b1, 1'b1, 1'b1, 16'd0,    1'b0, 24'd2},
		'{8'h00, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'hA5, 1'b0, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h3C, 1'b0, 1'b1, 1'b1, 16'd4096, 1'b0, 24'd2},
		'{8'h00, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h01, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h02, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h03, 1'b1, 1'b1, 1'b1, 16'd8192, 1'b0, 24'd4},
		'{8'h55, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'hAA, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h0F, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h55, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'hF0, 1'b1, 1'b1, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h80, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h7F, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'hFE, 1'b1, 1'b0, 1'b0, 16'd0,    1'b0, 24'd0},
		'{8'h01, 1'b1, 1'b1, 1'b0, 16'd0,    1'b0, 24'd0}
	};

	logic [15:0] phase_thresh[] = '{16'd0, 16'd32768, 16'd65535, 16'd8192, 16'd20000, 16'd1};

	initial begin
		int phase_items;
		clear_hist();
		threshold = ThresholdReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i]);
		drain();
		for (int p = 0; p < phase_thresh.size() + 2; p++) begin
			write_threshold(p < phase_thresh.size() ? phase_thresh[p] : 16'($urandom_range(0, 32768)));
			if (p == 2)
				hold_reqs++;
			phase_items = items_sent + RandItems / (phase_thresh.size() + 2);
			while (items_sent < phase_items)
				send_file();
			drain();
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
